[sv/odrp_pkg.sv]
package odrp_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int TAN_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = DIFF_W + TAN_W;
  localparam int LAYER_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Slope thresholds in Q16.
  localparam logic [TAN_W-1:0] TAN30_Q16 = 17'd37837;
  localparam logic [TAN_W-1:0] TAN60_Q16 = 17'd113512;

  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANY_ANGLE  = 2'd1;

  localparam logic [1:0] MODE_SNAP       = 2'd0;
  localparam logic [1:0] MODE_KNEE_START = 2'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic [LAYER_W-1:0]        layer;
    logic                      swap_way;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [LAYER_W-1:0]        layer;
    logic                      last;
  } seg_t;

  typedef struct packed {
    seg_t seg0;
    seg_t seg1;
    logic two;
  } plan_t;

  typedef struct packed {
    logic [1:0] refraction_mode;
    logic       any_angle;
  } cfg_t;

endpackage

[sv/odrp_if.sv]
interface odrp_req_if;
  logic                               valid;
  logic                               ready;
  logic signed [odrp_pkg::COORD_W-1:0] start_x;
  logic signed [odrp_pkg::COORD_W-1:0] start_y;
  logic signed [odrp_pkg::COORD_W-1:0] target_x;
  logic signed [odrp_pkg::COORD_W-1:0] target_y;
  logic [odrp_pkg::LAYER_W-1:0]        layer;
  logic                               swap_way;

  modport source (output valid, start_x, start_y, target_x, target_y, layer, swap_way,
                  input ready);
  modport sink (input valid, start_x, start_y, target_x, target_y, layer, swap_way,
                output ready);
endinterface

interface odrp_seg_if;
  logic                               valid;
  logic                               ready;
  logic signed [odrp_pkg::COORD_W-1:0] seg_x1;
  logic signed [odrp_pkg::COORD_W-1:0] seg_y1;
  logic signed [odrp_pkg::COORD_W-1:0] seg_x2;
  logic signed [odrp_pkg::COORD_W-1:0] seg_y2;
  logic [odrp_pkg::LAYER_W-1:0]        seg_layer;
  logic                               last;

  modport source (output valid, seg_x1, seg_y1, seg_x2, seg_y2, seg_layer, last,
                  input ready);
  modport sink (input valid, seg_x1, seg_y1, seg_x2, seg_y2, seg_layer, last,
                output ready);
endinterface

interface odrp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [odrp_pkg::CFG_IDX_W-1:0]        index;
  logic [odrp_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/odrp_plan.sv]
module odrp_plan (
  input  odrp_pkg::req_t  req,
  input  odrp_pkg::cfg_t  cfg,
  output odrp_pkg::plan_t plan
);

  localparam int CW = odrp_pkg::COORD_W;
  localparam int DW = odrp_pkg::DIFF_W;
  localparam int PW = odrp_pkg::PROD_W;

  function automatic logic signed [CW-1:0] move_c(input logic signed [CW-1:0] c,
                                                  input logic [DW-1:0] mag,
                                                  input logic neg);
    logic [DW-1:0] ce;
    ce = DW'(c);
    return CW'(neg ? ce - mag : ce + mag);
  endfunction

  logic signed [DW-1:0] dx, dy;
  logic                 nx, ny;
  logic [DW-1:0]        ax, ay, amin;
  logic [PW-1:0]        lhs, rhs30, rhs60;
  logic                 gt30, gt60, way, x_wider;
  logic signed [CW-1:0] ex, ey, kx, ky;
  logic                 leg0, leg1;

  always_comb begin
    dx = DW'(req.target_x) - DW'(req.start_x);
    dy = DW'(req.target_y) - DW'(req.start_y);
    nx = dx[DW-1];
    ny = dy[DW-1];
    ax = nx ? DW'(-dx) : DW'(dx);
    ay = ny ? DW'(-dy) : DW'(dy);
    amin = (ax < ay) ? ax : ay;
    x_wider = ax > ay;

    // Exact slope tests: ay * 2^16 against ax * tan.
    lhs   = PW'(ay) << odrp_pkg::FRAC_W;
    rhs30 = PW'(ax) * PW'(odrp_pkg::TAN30_Q16);
    rhs60 = PW'(ax) * PW'(odrp_pkg::TAN60_Q16);
    gt30  = lhs > rhs30;
    gt60  = lhs > rhs60;

    // Snapped end point.
    ex = req.target_x;
    ey = req.target_y;
    if (ax == '0 || gt60) begin
      ex = req.start_x;
    end else if (gt30) begin
      ex = move_c(req.start_x, amin, nx);
      ey = move_c(req.start_y, amin, ny);
    end else begin
      ey = req.start_y;
    end

    // Knee point.
    way = (cfg.refraction_mode != odrp_pkg::MODE_KNEE_START) ^ req.swap_way;
    if (!way) begin
      if (x_wider) begin
        kx = move_c(req.target_x, ay, !nx);
        ky = req.start_y;
      end else begin
        kx = req.start_x;
        ky = move_c(req.target_y, ax, !ny);
      end
    end else begin
      if (x_wider) begin
        kx = move_c(req.start_x, ay, nx);
        ky = req.target_y;
      end else begin
        kx = req.target_x;
        ky = move_c(req.start_y, ax, ny);
      end
    end
    leg0 = (kx != req.start_x) || (ky != req.start_y);
    leg1 = (kx != req.target_x) || (ky != req.target_y);

    plan.seg0.layer = req.layer;
    plan.seg1.layer = req.layer;
    plan.seg1.x1 = kx;
    plan.seg1.y1 = ky;
    plan.seg1.x2 = req.target_x;
    plan.seg1.y2 = req.target_y;
    plan.seg1.last = 1'b1;
    plan.seg0.x1 = req.start_x;
    plan.seg0.y1 = req.start_y;
    plan.seg0.last = 1'b1;
    plan.two = 1'b0;

    if (cfg.any_angle || (ax == '0 && ay == '0)) begin
      plan.seg0.x2 = req.target_x;
      plan.seg0.y2 = req.target_y;
    end else if (cfg.refraction_mode == odrp_pkg::MODE_SNAP) begin
      plan.seg0.x2 = ex;
      plan.seg0.y2 = ey;
    end else if (leg0 && leg1) begin
      plan.seg0.x2 = kx;
      plan.seg0.y2 = ky;
      plan.seg0.last = 1'b0;
      plan.two = 1'b1;
    end else if (leg0) begin
      plan.seg0.x2 = kx;
      plan.seg0.y2 = ky;
    end else begin
      // Knee sits on the start: only the second leg remains.
      plan.seg0.x2 = req.target_x;
      plan.seg0.y2 = req.target_y;
    end
  end

endmodule

[sv/odrp_seg_buf.sv]
module odrp_seg_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  odrp_pkg::plan_t in_plan,
  output logic            take,
  odrp_seg_if.source      seg
);

  logic            full;
  logic            idx;
  odrp_pkg::plan_t held;
  odrp_pkg::seg_t  cur;
  logic            final_beat;
  logic            out_acc;

  always_comb begin
    cur        = idx ? held.seg1 : held.seg0;
    final_beat = !held.two || idx;
    out_acc    = full && seg.ready;
    take       = !full || (seg.ready && final_beat);
  end

  assign seg.valid     = full;
  assign seg.seg_x1    = cur.x1;
  assign seg.seg_y1    = cur.y1;
  assign seg.seg_x2    = cur.x2;
  assign seg.seg_y2    = cur.y2;
  assign seg.seg_layer = cur.layer;
  assign seg.last      = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 1'b0;
    end else if (take && in_valid) begin
      full <= 1'b1;
      idx  <= 1'b0;
    end else if (out_acc && !final_beat) begin
      idx <= 1'b1;
    end else if (out_acc) begin
      full <= 1'b0;
      idx  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      held <= in_plan;
    end
  end

  a_idx_two: assert property (@(posedge clk) disable iff (rst) (full && idx) |-> held.two)
    else $error("second segment selected for a single-segment route");
  a_last_final: assert property (@(posedge clk) disable iff (rst) full |-> (seg.last == final_beat))
    else $error("last mark disagrees with the beat sequence");
  a_step: assert property (@(posedge clk) disable iff (rst)
      (out_acc && !final_beat) |=> (full && idx))
    else $error("second segment lost after the first beat");
  a_load: assert property (@(posedge clk) disable iff (rst) (take && in_valid) |=> (full && !idx))
    else $error("new route not loaded at its first segment");

endmodule

[sv/orthogonal_diagonal_route_planner_top.sv]
// Route planner: joins a start point to a target point with one or two segments
// running horizontally, vertically or at 45 degrees, or one direct segment under any_angle.
// The req channel carries one route request per beat: start and target points, a layer
// and the swap flag. The seg channel returns one segment per beat, with last set on the
// final segment of each route. The cfg channel writes refraction_mode (index 0) and
// any_angle (index 1); it is always ready and should only be used while the block is idle.
// A request passes through an input register, is planned by combinational logic and
// lands in a two-segment result register, from which its segments are offered on the
// seg channel. A route of one segment needs one seg beat and a knee route two, so while
// the receiver keeps ready high, single-segment routes flow at one request per cycle,
// while knee routes are held back by the single segment per seg beat.
// A new request is taken while the previous route's final segment is being delivered.
// When the receiver stalls, the result register holds its segment steady and the input
// register fills, after which req.ready drops until the result register frees.
// Synchronous reset empties both registers and returns both configuration registers
// to zero (snapped single segment, any-angle off).
module orthogonal_diagonal_route_planner_top (
  input  logic       clk,
  input  logic       rst,
  odrp_req_if.sink   req,
  odrp_seg_if.source seg,
  odrp_cfg_if.sink   cfg
);

  odrp_pkg::cfg_t  cfg_regs;
  odrp_pkg::req_t  s1_req;
  logic            s1_valid;
  logic            buf_take;
  odrp_pkg::plan_t plan;

  // Configuration writes are taken on every beat; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.refraction_mode <= 2'd0;
      cfg_regs.any_angle       <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        odrp_pkg::CFG_REFRACTION: cfg_regs.refraction_mode <= cfg.data;
        odrp_pkg::CFG_ANY_ANGLE:  cfg_regs.any_angle       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // The input register can refill in the same cycle that its content moves on.
  assign req.ready = !s1_valid || buf_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req.start_x  <= req.start_x;
      s1_req.start_y  <= req.start_y;
      s1_req.target_x <= req.target_x;
      s1_req.target_y <= req.target_y;
      s1_req.layer    <= req.layer;
      s1_req.swap_way <= req.swap_way;
    end
  end

  odrp_plan u_plan (
    .req  (s1_req),
    .cfg  (cfg_regs),
    .plan (plan)
  );

  odrp_seg_buf u_seg_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_plan  (plan),
    .take     (buf_take),
    .seg      (seg)
  );

endmodule

[test/tb_orthogonal_diagonal_route_planner_top.sv]
module tb_orthogonal_diagonal_route_planner_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = odrp_pkg::COORD_W;
  localparam int DW = odrp_pkg::DIFF_W;
  localparam int LW = odrp_pkg::LAYER_W;
  localparam int IW = odrp_pkg::CFG_IDX_W;
  localparam int VW = odrp_pkg::CFG_DATA_W;
  localparam int FW = odrp_pkg::FRAC_W;

  // Generous ceiling on the whole run, well clear of the slowest correct run, which sends
  // every route as a knee route with every segment held off by the longest stall.
  localparam int LIMIT = 200000;
  // Cycles let pass once the last segment has arrived, so that the two-stage pipe
  // is certainly empty before a register is touched.
  localparam int SETTLE = 8;

  localparam logic [1:0] MODE_KNEE_TARGET = 2'd2;
  localparam logic [1:0] MODE_KNEE_ALT    = 2'd3;
  localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = ~CMIN;

  logic clk;
  logic rst;

  odrp_req_if req ();
  odrp_seg_if seg ();
  odrp_cfg_if cfg ();

  orthogonal_diagonal_route_planner_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .seg(seg),
    .cfg(cfg)
  );

  // Routes waiting to be sent, and the segments the planner is expected to return,
  // oldest first.
  odrp_pkg::req_t route_queue[$];
  odrp_pkg::seg_t planned_segs[$];

  // Our own copy of the two configuration registers, updated on each cfg beat.
  logic [1:0] mode_q;
  logic       any_q;

  odrp_pkg::req_t on_wire;
  int   send_gap;
  int   sink_gap;
  int   idle_pct;
  int   errors;
  int   cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every mismatch comes through here: one line each, and counted.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] got,
                             input logic [CW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // True when rise / run is strictly above the Q16 slope tan_q. Both sides are exact:
  // a 33-bit magnitude shifted by 16 or multiplied by 17 bits fits well inside 64.
  function automatic logic steeper(input logic [DW-1:0] rise,
                                   input logic [DW-1:0] run,
                                   input logic [odrp_pkg::TAN_W-1:0] tan_q);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(rise) << FW;
    rhs = 64'(run) * 64'(tan_q);
    return lhs > rhs;
  endfunction

  // Moves a coordinate by mag, downwards when down is set. Every point produced this
  // way lies between start and target, so wrapping at 32 bits never happens.
  function automatic logic [CW-1:0] step_toward(input logic [CW-1:0] c,
                                                input logic [DW-1:0] mag,
                                                input logic down);
    return down ? c - mag[CW-1:0] : c + mag[CW-1:0];
  endfunction

  // Works out the segments for one route under the current configuration and appends
  // them to planned_segs.
  function automatic void plan_route(input odrp_pkg::req_t r);
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [DW-1:0] ax;
    logic [DW-1:0] ay;
    logic [DW-1:0] m;
    logic nx;
    logic ny;
    logic way;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic [CW-1:0] kx;
    logic [CW-1:0] ky;
    odrp_pkg::seg_t s;
    dx = {r.target_x[CW-1], r.target_x} - {r.start_x[CW-1], r.start_x};
    dy = {r.target_y[CW-1], r.target_y} - {r.start_y[CW-1], r.start_y};
    nx = dx[DW-1];
    ny = dy[DW-1];
    ax = nx ? -dx : dx;
    ay = ny ? -dy : dy;
    s.layer = r.layer;
    s.x1 = r.start_x;
    s.y1 = r.start_y;
    if (any_q || (ax == 0 && ay == 0)) begin
      // A direct segment, which also covers a route that goes nowhere.
      s.x2 = r.target_x;
      s.y2 = r.target_y;
      s.last = 1'b1;
      planned_segs.push_back(s);
    end else if (mode_q == odrp_pkg::MODE_SNAP) begin
      ex = r.target_x;
      ey = r.target_y;
      if (ax == 0 || steeper(ay, ax, odrp_pkg::TAN60_Q16)) begin
        ex = r.start_x;
      end else if (steeper(ay, ax, odrp_pkg::TAN30_Q16)) begin
        m = (ax < ay) ? ax : ay;
        ex = step_toward(r.start_x, m, nx);
        ey = step_toward(r.start_y, m, ny);
      end else begin
        ey = r.start_y;
      end
      s.x2 = ex;
      s.y2 = ey;
      s.last = 1'b1;
      planned_segs.push_back(s);
    end else begin
      // Knee modes: the straight leg comes first or last, and swap_way flips that.
      way = (mode_q != odrp_pkg::MODE_KNEE_START) ^ r.swap_way;
      if (!way) begin
        if (ax > ay) begin
          kx = step_toward(r.target_x, ay, !nx);
          ky = r.start_y;
        end else begin
          kx = r.start_x;
          ky = step_toward(r.target_y, ax, !ny);
        end
      end else begin
        if (ax > ay) begin
          kx = step_toward(r.start_x, ay, nx);
          ky = r.target_y;
        end else begin
          kx = r.target_x;
          ky = step_toward(r.start_y, ax, ny);
        end
      end
      if (kx != r.start_x || ky != r.start_y) begin
        s.x2 = kx;
        s.y2 = ky;
        s.last = (kx == r.target_x && ky == r.target_y);
        planned_segs.push_back(s);
      end
      if (kx != r.target_x || ky != r.target_y) begin
        s.x1 = kx;
        s.y1 = ky;
        s.x2 = r.target_x;
        s.y2 = r.target_y;
        s.last = 1'b1;
        planned_segs.push_back(s);
      end
    end
  endfunction

  function automatic odrp_pkg::req_t route(input logic signed [CW-1:0] sx,
                                           input logic signed [CW-1:0] sy,
                                           input logic signed [CW-1:0] tx,
                                           input logic signed [CW-1:0] ty,
                                           input logic [LW-1:0] layer,
                                           input logic swap_way);
    odrp_pkg::req_t r;
    r.start_x = sx;
    r.start_y = sy;
    r.target_x = tx;
    r.target_y = ty;
    r.layer = layer;
    r.swap_way = swap_way;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random route. Most routes stay within a window around the start so that every
  // slope class is reached, including slopes within one unit of tan30 and tan60, and
  // exact diagonals. The rest span the full coordinate range or sit on its corners.
  function automatic odrp_pkg::req_t make_route();
    odrp_pkg::req_t r;
    logic [63:0] span;
    logic [63:0] run;
    logic [63:0] rise;
    logic [63:0] run_x;
    logic [63:0] run_y;
    int kind;
    r.layer = LW'($urandom);
    r.swap_way = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 11);
    r.start_x = $urandom;
    r.start_y = $urandom;
    r.target_x = $urandom;
    r.target_y = $urandom;
    if (kind == 1) begin
      r.start_x = pick_extreme();
      r.start_y = pick_extreme();
      r.target_x = pick_extreme();
      r.target_y = pick_extreme();
    end else if (kind >= 2) begin
      // Keep the start within the middle half of the range so the offset cannot wrap.
      r.start_x = r.start_x >>> 1;
      r.start_y = r.start_y >>> 1;
      span = 64'd1 << $urandom_range(2, 28);
      run = 64'($urandom_range(0, 32'(span)));
      case (kind)
        2, 3: rise = run;
        4: rise = '0;
        5, 6: rise = ((run * odrp_pkg::TAN30_Q16) >> FW) + 64'($urandom_range(0, 2));
        7, 8: rise = ((run * odrp_pkg::TAN60_Q16) >> FW) + 64'($urandom_range(0, 2));
        9: begin
          run = '0;
          rise = '0;
        end
        default: rise = 64'($urandom_range(0, 32'(span)));
      endcase
      if (kind >= 5 && kind <= 8 && rise != 0) begin
        rise = rise - 64'd1;
      end
      if ($urandom_range(0, 1)) begin
        run_x = run;
        run_y = rise;
      end else begin
        run_x = rise;
        run_y = run;
      end
      r.target_x = $urandom_range(0, 1) ? r.start_x - run_x[CW-1:0]
                                        : r.start_x + run_x[CW-1:0];
      r.target_y = $urandom_range(0, 1) ? r.start_y - run_y[CW-1:0]
                                        : r.start_y + run_y[CW-1:0];
    end
    return r;
  endfunction

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mirror of the configuration registers; only indexes 0 and 1 hold anything.
  always @(posedge clk) begin
    if (rst) begin
      mode_q <= odrp_pkg::MODE_SNAP;
      any_q <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == odrp_pkg::CFG_REFRACTION) begin
        mode_q <= cfg.data;
      end else if (cfg.index == odrp_pkg::CFG_ANY_ANGLE) begin
        any_q <= cfg.data[0];
      end
    end
  end

  // Request driver. A route is planned at the beat that hands it over, using the
  // configuration then in force. The payload only changes once the current beat has
  // been taken, and valid gets at most one assignment per edge so it stays high
  // through back-to-back beats.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        plan_route(on_wire);
      end
      if (!req.valid || req.ready) begin
        if (send_gap == 0 && route_queue.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 3);
        end
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (route_queue.size() != 0) begin
          on_wire = route_queue.pop_front();
          req.valid <= 1'b1;
          req.start_x <= on_wire.start_x;
          req.start_y <= on_wire.start_y;
          req.target_x <= on_wire.target_x;
          req.target_y <= on_wire.target_y;
          req.layer <= on_wire.layer;
          req.swap_way <= on_wire.swap_way;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Segment monitor. Each beat is checked field by field against the oldest planned
  // segment; ready is dropped in short random bursts to stall the planner.
  always @(posedge clk) begin
    if (rst) begin
      seg.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (seg.valid && seg.ready) begin
        if (planned_segs.size() == 0) begin
          report_mismatch($sformatf("segment (%h,%h)-(%h,%h) with no route pending",
                                    seg.seg_x1, seg.seg_y1, seg.seg_x2, seg.seg_y2));
        end else begin
          check_field("seg_x1", seg.seg_x1, planned_segs[0].x1);
          check_field("seg_y1", seg.seg_y1, planned_segs[0].y1);
          check_field("seg_x2", seg.seg_x2, planned_segs[0].x2);
          check_field("seg_y2", seg.seg_y2, planned_segs[0].y2);
          check_field("seg_layer", CW'(seg.seg_layer), CW'(planned_segs[0].layer));
          check_field("last", CW'(seg.last), CW'(planned_segs[0].last));
          void'(planned_segs.pop_front());
        end
      end
      if (sink_gap == 0 && $urandom_range(0, 99) < idle_pct) begin
        sink_gap = $urandom_range(1, 3);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        seg.ready <= 1'b0;
      end else begin
        seg.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [IW-1:0] idx, input logic [VW-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Holds the test sequence back until every queued route has gone and every planned
  // segment has come back, then lets the pipe settle.
  task automatic drain();
    while (route_queue.size() != 0 || req.valid || planned_segs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic [VW-1:0] any,
                           input int count, input int pct);
    write_reg(odrp_pkg::CFG_REFRACTION, mode);
    write_reg(odrp_pkg::CFG_ANY_ANGLE, any);
    idle_pct = pct;
    repeat (count) route_queue.push_back(make_route());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    req.valid = 1'b0;
    req.start_x = '0;
    req.start_y = '0;
    req.target_x = '0;
    req.target_y = '0;
    req.layer = '0;
    req.swap_way = 1'b0;
    seg.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed routes under the reset configuration, which is snapped mode: a route
    // that goes nowhere, a vertical with no x change, steep, shallow and diagonal
    // slopes in several quadrants, the extremes of the coordinate range, and slopes
    // exactly on tan30 and tan60, which are not strictly above and so fall to the
    // flatter side, next to slopes one unit steeper.
    idle_pct = 20;
    route_queue.push_back(route(5, 5, 5, 5, 8'hff, 1'b1));
    route_queue.push_back(route(0, 0, 0, 100, 8'h01, 1'b0));
    route_queue.push_back(route(0, 0, 10, 100, 8'h02, 1'b0));
    route_queue.push_back(route(0, 0, 100, 10, 8'h04, 1'b0));
    route_queue.push_back(route(0, 0, 100, -90, 8'h08, 1'b0));
    route_queue.push_back(route(10, 10, -60, -50, 8'h10, 1'b1));
    route_queue.push_back(route(CMIN, CMIN, CMAX, CMAX, 8'h00, 1'b0));
    route_queue.push_back(route(CMAX, 0, CMIN, 1, 8'h20, 1'b0));
    route_queue.push_back(route(0, 0, 65536, 37837, 8'h40, 1'b0));
    route_queue.push_back(route(0, 0, 65536, 37838, 8'h80, 1'b0));
    route_queue.push_back(route(0, 0, 65536, 113512, 8'h55, 1'b0));
    route_queue.push_back(route(0, 0, 65536, 113513, 8'haa, 1'b0));
    drain();

    // Knee on the start side: wide and tall routes with and without the swap, a
    // route with equal x and y spans (treated as the tall case, so the knee lands on
    // the start and only one leg remains), a flat route, and the extreme corners.
    write_reg(odrp_pkg::CFG_REFRACTION, odrp_pkg::MODE_KNEE_START);
    route_queue.push_back(route(0, 0, 100, 30, 8'h11, 1'b0));
    route_queue.push_back(route(0, 0, 30, 100, 8'h22, 1'b1));
    route_queue.push_back(route(0, 0, 50, -50, 8'h33, 1'b0));
    route_queue.push_back(route(0, 0, 100, 0, 8'h44, 1'b1));
    route_queue.push_back(route(CMIN, CMAX, CMAX, CMIN, 8'h66, 1'b1));
    drain();

    // Knee on the target side, then the spare mode value, which acts the same.
    write_reg(odrp_pkg::CFG_REFRACTION, MODE_KNEE_TARGET);
    route_queue.push_back(route(0, 0, -100, 30, 8'h77, 1'b0));
    route_queue.push_back(route(0, 0, 30, -100, 8'h88, 1'b1));
    route_queue.push_back(route(7, 7, 7, 7, 8'h99, 1'b0));
    drain();
    write_reg(odrp_pkg::CFG_REFRACTION, MODE_KNEE_ALT);
    route_queue.push_back(route(0, 0, 100, 30, 8'hbb, 1'b0));
    drain();

    // Any-angle overrides everything, even for a route that goes nowhere. Writes to
    // the unused indexes must leave both registers alone.
    write_reg(odrp_pkg::CFG_REFRACTION, odrp_pkg::MODE_SNAP);
    write_reg(odrp_pkg::CFG_ANY_ANGLE, 2'd1);
    write_reg(CFG_SPARE_A, 2'd3);
    write_reg(CFG_SPARE_B, 2'd0);
    route_queue.push_back(route(3, 3, 3, 3, 8'hcc, 1'b0));
    route_queue.push_back(route(CMIN, CMAX, CMAX, CMIN, 8'hdd, 1'b1));
    drain();

    // Random part, one phase per setting. Writing 2 to any_angle checks that only its
    // low bit counts. One middle phase runs with no idling at all, and so does the
    // final phase.
    run_phase(odrp_pkg::MODE_SNAP, 2'd0, 250, 30);
    run_phase(odrp_pkg::MODE_KNEE_START, 2'd0, 250, 50);
    run_phase(MODE_KNEE_TARGET, 2'd0, 250, 20);
    run_phase(MODE_KNEE_ALT, 2'd0, 120, 0);
    run_phase(2'($urandom_range(0, 3)), 2'd1, 100, 30);
    run_phase(odrp_pkg::MODE_KNEE_START, 2'd2, 130, 40);
    run_phase(odrp_pkg::MODE_SNAP, 2'd0, 250, 0);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/odrp_pkg.sv
sv/odrp_if.sv
sv/odrp_plan.sv
sv/odrp_seg_buf.sv
sv/orthogonal_diagonal_route_planner_top.sv
test/tb_orthogonal_diagonal_route_planner_top.sv
